// ----- hw/rtl/wvc_pkg.sv -----
// Shared constants, arctangent table and gain functions for the waypoint velocity command block.
package wvc_pkg;

   localparam int GUARD_BITS = 8;
   localparam int ATAN_LEN   = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 112;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_TOL     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DIST_TOL      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIN_SPEED_MAX = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANG_SPEED_MAX = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIN_NEAR      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANG_NEAR      = 3'd5;

   // atan(2^-i), 2^32 units per turn
   localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // table entry rounded to aw bits per turn
   function automatic logic [31:0] atan_round(input int idx, input int aw);
      logic [32:0] t;
      t = 33'(ATAN_TAB[idx]) + (33'(1) << (31 - aw));
      return 32'(t >> (32 - aw));
   endfunction

   // 1/K^2 in Q30 for n stages
   function automatic logic [63:0] inv_gain_sq(input int n);
      logic [63:0] p;
      logic [63:0] d;
      logic [63:0] q;
      logic [63:0] r;
      int i;
      p = 64'(1) << 60;
      for (i = 0; i < n; i++) begin
         p = p + (p >> (2 * i));
      end
      d = p >> 30;
      q = '0;
      r = '0;
      for (i = 60; i >= 0; i--) begin
         r = (r << 1) | ((i == 60) ? 64'(1) : 64'(0));
         if (r >= d) begin
            r = r - d;
            q = q | (64'(1) << i);
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      n = n_in;
      r = '0;
      b = 64'(1) << 62;
      while (b > n) begin
         b = b >> 2;
      end
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/waypoint_velocity_command.sv -----
// Throughput: one item per cycle while the output is not stalled; vectoring CORDIC,
// rotation CORDIC, split multiplier and a 24-stage restoring divider are all fully
// pipelined, one iteration per stage.
// Each stage holds its item until the next stage frees, so bubbles close up under stall.
// Reset: synchronous, clears all valid bits and loads register defaults; no clearing pass.
module waypoint_velocity_command #(
   parameter int POS_WIDTH     = 32,
   parameter int ANGLE_WIDTH   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // robot_x, robot_y, robot_yaw, target_x, target_y, waypoints_to_go
   input  logic [wvc_pkg::REQ_DATA_W-1:0]         req_tdata,
   // preempt
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // linear_speed, angular_speed, distance_left, bearing_left, reached, waypoints_left
   output logic [wvc_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // preempted
   output logic                                   rsp_tuser,
   input  logic                                   csr_we,
   input  logic [wvc_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  logic [wvc_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int W     = POS_WIDTH + 12;
   localparam int N     = CORDIC_STAGES;
   localparam int AW    = ANGLE_WIDTH;
   localparam int ZW    = AW + 2;
   localparam int DB    = 24;
   localparam int OFFW  = (W - 7 > 33) ? W - 7 : 33;
   localparam int R0    = N + 1;
   localparam int MUL0  = 2 * N + 2;
   localparam int DIV0  = MUL0 + 4;
   localparam int OUTS  = DIV0 + DB + 1;
   localparam int NS    = OUTS + 1;

   localparam logic [63:0] INVK2 = wvc_pkg::inv_gain_sq(N);
   localparam logic [63:0] INVK  = wvc_pkg::isqrt64(INVK2 << 30);
   localparam logic [31:0] INVK2_C = INVK2[31:0];
   localparam logic [31:0] INVK_C  = INVK[31:0];

   localparam logic [AW-1:0]        HALF_AW = AW'(1) << (AW - 1);
   localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (AW - 2);
   localparam logic signed [ZW-1:0] HALF_Z  = ZW'(1) << (AW - 1);

   typedef struct packed {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic [AW-1:0]       z;
      logic [AW-1:0]       yaw;
      logic                zero;
      logic [15:0]         wtg;
      logic                pre;
   } vec_type;

   typedef struct packed {
      logic signed [W-1:0]  x;
      logic signed [W-1:0]  y;
      logic signed [ZW-1:0] zr;
      logic [W-1:0]         mag;
      logic [15:0]          b16;
      logic [15:0]          wtg;
      logic                 pre;
   } rot_type;

   typedef struct packed {
      logic            lneg;
      logic [63:0]     lx;
      logic [63:0]     mg;
      logic [63:0]     pl_lo;
      logic [63:0]     pd_lo;
      logic [63:0]     pl_hi;
      logic [63:0]     pd_hi;
      logic [OFFW-1:0] lxa;
      logic [OFFW-1:0] dmag;
      logic [15:0]     b16;
      logic [15:0]     wtg;
      logic            pre;
   } mul_type;

   typedef struct packed {
      logic [47:0] num;
      logic [23:0] den;
      logic [23:0] rem;
      logic [23:0] quo;
   } lane_type;

   typedef struct packed {
      lane_type [1:0] lane;   // 0 forward speed, 1 turn rate
      logic           lneg;
      logic           lzero;
      logic           lsat;
      logic           azero;
      logic           asat;
      logic [31:0]    dist32;
      logic           reached;
      logic [15:0]    b16;
      logic [15:0]    wtg;
      logic           pre;
   } div_type;

   // configuration registers
   logic [14:0] angle_tol_ff;
   logic [23:0] dist_tol_ff;
   logic [23:0] lin_max_ff;
   logic [19:0] ang_max_ff;
   logic [23:0] lin_near_ff;
   logic [14:0] ang_near_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_tol_ff <= 15'd91;
         dist_tol_ff  <= 24'd6554;
         lin_max_ff   <= 24'd26214;
         ang_max_ff   <= 20'd22876;
         lin_near_ff  <= 24'd78643;
         ang_near_ff  <= 15'd1820;
      end else if (csr_we) begin
         unique case (csr_addr)
            wvc_pkg::CSR_ANGLE_TOL:     angle_tol_ff <= csr_wdata[14:0];
            wvc_pkg::CSR_DIST_TOL:      dist_tol_ff  <= csr_wdata;
            wvc_pkg::CSR_LIN_SPEED_MAX: lin_max_ff   <= csr_wdata;
            wvc_pkg::CSR_ANG_SPEED_MAX: ang_max_ff   <= csr_wdata[19:0];
            wvc_pkg::CSR_LIN_NEAR:      lin_near_ff  <= csr_wdata;
            wvc_pkg::CSR_ANG_NEAR:      ang_near_ff  <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // stage valids and advance chain
   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_prev;
   logic [NS-1:0] mv;

   always_comb begin
      mv[NS-1] = !v_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         mv[i] = !v_ff[i] || mv[i+1];
      end
   end

   assign v_prev     = {v_ff[NS-2:0], req_tvalid};
   assign req_tready = mv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (mv[i]) begin
               v_ff[i] <= v_prev[i];
            end
         end
      end
   end

   // ---------------- vectoring CORDIC ----------------
   vec_type vec_ff [0:N];
   vec_type vec_nx [0:N];

   logic [POS_WIDTH-1:0]      rx, ry, tx, ty;
   logic signed [POS_WIDTH:0] dx, dy;
   logic signed [W-1:0]       x0, y0;
   logic [15:0]               yaw_in;
   logic [AW-1:0]             yaw_aw;

   assign rx     = POS_WIDTH'(req_tdata[31:0]);
   assign ry     = POS_WIDTH'(req_tdata[63:32]);
   assign yaw_in = req_tdata[79:64];
   assign tx     = POS_WIDTH'(req_tdata[111:80]);
   assign ty     = POS_WIDTH'(req_tdata[143:112]);
   assign dx     = (POS_WIDTH+1)'($signed(tx)) - (POS_WIDTH+1)'($signed(rx));
   assign dy     = (POS_WIDTH+1)'($signed(ty)) - (POS_WIDTH+1)'($signed(ry));
   assign x0     = W'(dx) <<< wvc_pkg::GUARD_BITS;
   assign y0     = W'(dy) <<< wvc_pkg::GUARD_BITS;

   generate
      if (AW >= 16) begin : g_yaw_wide
         assign yaw_aw = AW'(AW'(yaw_in) << (AW - 16));
      end else begin : g_yaw_narrow
         assign yaw_aw = AW'((17'(yaw_in) + (17'(1) << (15 - AW))) >> (16 - AW));
      end
   endgenerate

   always_comb begin
      logic signed [W-1:0] xs;
      logic signed [W-1:0] ys;
      logic [AW-1:0]       at;
      vec_nx[0].x    = (x0 < 0) ? -x0 : x0;
      vec_nx[0].y    = (x0 < 0) ? -y0 : y0;
      vec_nx[0].z    = (x0 < 0) ? HALF_AW : '0;
      vec_nx[0].yaw  = yaw_aw;
      vec_nx[0].zero = (dx == 0) && (dy == 0);
      vec_nx[0].wtg  = req_tdata[159:144];
      vec_nx[0].pre  = req_tuser;
      for (int i = 1; i <= N; i++) begin
         vec_nx[i] = vec_ff[i-1];
         xs = vec_ff[i-1].x >>> (i - 1);
         ys = vec_ff[i-1].y >>> (i - 1);
         at = AW'(wvc_pkg::atan_round(i - 1, AW));
         if (vec_ff[i-1].y >= 0) begin
            vec_nx[i].x = vec_ff[i-1].x + ys;
            vec_nx[i].y = vec_ff[i-1].y - xs;
            vec_nx[i].z = vec_ff[i-1].z + at;
         end else begin
            vec_nx[i].x = vec_ff[i-1].x - ys;
            vec_nx[i].y = vec_ff[i-1].y + xs;
            vec_nx[i].z = vec_ff[i-1].z - at;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= N; i++) begin
         if (mv[i]) begin
            vec_ff[i] <= vec_nx[i];
         end
      end
   end

   // ---------------- rotation CORDIC ----------------
   rot_type rot_ff [0:N];
   rot_type rot_nx [0:N];

   logic [AW-1:0]        bear;
   logic [15:0]          b16;
   logic signed [ZW-1:0] zb;
   logic signed [W-1:0]  vx_abs, vx_nabs;

   assign bear    = vec_ff[N].zero ? '0 : (vec_ff[N].z - vec_ff[N].yaw);
   assign zb      = ZW'($signed(bear));
   assign vx_abs  = (vec_ff[N].x < 0) ? -vec_ff[N].x : vec_ff[N].x;
   assign vx_nabs = (vec_ff[N].x < 0) ? vec_ff[N].x : -vec_ff[N].x;

   generate
      if (AW > 16) begin : g_b16_round
         assign b16 = 16'((AW'(bear) + (AW'(1) << (AW - 17))) >> (AW - 16));
      end else begin : g_b16_shift
         assign b16 = 16'(16'(bear) << (16 - AW));
      end
   endgenerate

   always_comb begin
      logic signed [W-1:0]  xs;
      logic signed [W-1:0]  ys;
      logic signed [ZW-1:0] at;
      rot_nx[0].y   = '0;
      rot_nx[0].mag = $unsigned(vx_abs);
      rot_nx[0].b16 = b16;
      rot_nx[0].wtg = vec_ff[N].wtg;
      rot_nx[0].pre = vec_ff[N].pre;
      if (zb > QUARTER) begin
         rot_nx[0].x  = vx_nabs;
         rot_nx[0].zr = zb - HALF_Z;
      end else if (zb < -QUARTER) begin
         rot_nx[0].x  = vx_nabs;
         rot_nx[0].zr = zb + HALF_Z;
      end else begin
         rot_nx[0].x  = vx_abs;
         rot_nx[0].zr = zb;
      end
      for (int i = 1; i <= N; i++) begin
         rot_nx[i] = rot_ff[i-1];
         xs = rot_ff[i-1].x >>> (i - 1);
         ys = rot_ff[i-1].y >>> (i - 1);
         at = ZW'(wvc_pkg::atan_round(i - 1, AW));
         if (rot_ff[i-1].zr >= 0) begin
            rot_nx[i].x  = rot_ff[i-1].x - ys;
            rot_nx[i].y  = rot_ff[i-1].y + xs;
            rot_nx[i].zr = rot_ff[i-1].zr - at;
         end else begin
            rot_nx[i].x  = rot_ff[i-1].x + ys;
            rot_nx[i].y  = rot_ff[i-1].y - xs;
            rot_nx[i].zr = rot_ff[i-1].zr + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= N; i++) begin
         if (mv[R0+i]) begin
            rot_ff[i] <= rot_nx[i];
         end
      end
   end

   // ---------------- gain removal, products split at bit 32 ----------------
   mul_type mul_ff [0:3];
   mul_type mul_nx [0:3];
   logic signed [W-1:0] rx_abs;

   assign rx_abs = (rot_ff[N].x < 0) ? -rot_ff[N].x : rot_ff[N].x;

   always_comb begin
      mul_nx[0]      = mul_ff[0];
      mul_nx[0].lneg = rot_ff[N].x < 0;
      mul_nx[0].lx   = 64'($unsigned(rx_abs));
      mul_nx[0].mg   = 64'(rot_ff[N].mag);
      mul_nx[0].b16  = rot_ff[N].b16;
      mul_nx[0].wtg  = rot_ff[N].wtg;
      mul_nx[0].pre  = rot_ff[N].pre;

      mul_nx[1]       = mul_ff[0];
      mul_nx[1].pl_lo = mul_ff[0].lx[31:0] * INVK2_C;
      mul_nx[1].pd_lo = mul_ff[0].mg[31:0] * INVK_C;

      mul_nx[2]       = mul_ff[1];
      mul_nx[2].pl_hi = mul_ff[1].lx[63:32] * INVK2_C;
      mul_nx[2].pd_hi = mul_ff[1].mg[63:32] * INVK_C;

      mul_nx[3]      = mul_ff[2];
      mul_nx[3].lxa  = OFFW'(((96'(mul_ff[2].pl_hi) << 32) + 96'(mul_ff[2].pl_lo)) >> 38);
      mul_nx[3].dmag = OFFW'(((96'(mul_ff[2].pd_hi) << 32) + 96'(mul_ff[2].pd_lo)) >> 38);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (mv[MUL0+i]) begin
            mul_ff[i] <= mul_nx[i];
         end
      end
   end

   // ---------------- command thresholds and restoring divider ----------------
   div_type div_ff [0:DB];
   div_type div_nx [0:DB];

   logic signed [16:0] sb;
   logic [16:0]        ab;

   assign sb = {mul_ff[3].b16[15], mul_ff[3].b16};
   assign ab = (sb < 0) ? $unsigned(-sb) : $unsigned(sb);

   always_comb begin
      logic [24:0] t;
      div_nx[0].lneg    = mul_ff[3].lneg;
      div_nx[0].lzero   = mul_ff[3].lxa <= OFFW'(dist_tol_ff);
      div_nx[0].lsat    = mul_ff[3].lxa > OFFW'(lin_near_ff);
      div_nx[0].azero   = ab <= 17'(angle_tol_ff);
      div_nx[0].asat    = ab > 17'(ang_near_ff);
      div_nx[0].dist32  = (|mul_ff[3].dmag[OFFW-1:32]) ? '1 : mul_ff[3].dmag[31:0];
      div_nx[0].reached = !mul_ff[3].pre && (mul_ff[3].dmag < OFFW'(dist_tol_ff));
      div_nx[0].b16     = mul_ff[3].b16;
      div_nx[0].wtg     = mul_ff[3].wtg;
      div_nx[0].pre     = mul_ff[3].pre;
      div_nx[0].lane[0].num = 48'(lin_max_ff) * 48'(mul_ff[3].lxa[23:0]);
      div_nx[0].lane[0].den = lin_near_ff;
      div_nx[0].lane[1].num = 48'(ang_max_ff) * 48'(ab);
      div_nx[0].lane[1].den = 24'(ang_near_ff);
      for (int l = 0; l < 2; l++) begin
         div_nx[0].lane[l].rem = div_nx[0].lane[l].num[47:24];
         div_nx[0].lane[l].quo = '0;
      end
      for (int k = 1; k <= DB; k++) begin
         div_nx[k] = div_ff[k-1];
         for (int l = 0; l < 2; l++) begin
            t = {div_ff[k-1].lane[l].rem, div_ff[k-1].lane[l].num[DB-k]};
            if (t >= {1'b0, div_ff[k-1].lane[l].den}) begin
               div_nx[k].lane[l].rem         = 24'(t - {1'b0, div_ff[k-1].lane[l].den});
               div_nx[k].lane[l].quo[DB-k]   = 1'b1;
            end else begin
               div_nx[k].lane[l].rem = t[23:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= DB; i++) begin
         if (mv[DIV0+i]) begin
            div_ff[i] <= div_nx[i];
         end
      end
   end

   // ---------------- output register ----------------
   logic [24:0] lin_ff, lin_in;
   logic [20:0] ang_ff, ang_in;
   logic [31:0] dist_ff;
   logic [15:0] bear_ff;
   logic        reached_ff;
   logic [15:0] wtg_ff;
   logic        pre_ff;

   always_comb begin
      logic [23:0] lmag;
      logic [19:0] amag;
      if (div_ff[DB].pre || div_ff[DB].lzero) begin
         lmag = '0;
      end else if (div_ff[DB].lsat) begin
         lmag = lin_max_ff;
      end else begin
         lmag = div_ff[DB].lane[0].quo;
      end
      if (div_ff[DB].pre || div_ff[DB].azero) begin
         amag = '0;
      end else if (div_ff[DB].asat) begin
         amag = ang_max_ff;
      end else begin
         amag = div_ff[DB].lane[1].quo[19:0];
      end
      lin_in = div_ff[DB].lneg ? (25'd0 - 25'(lmag)) : 25'(lmag);
      ang_in = div_ff[DB].b16[15] ? (21'd0 - 21'(amag)) : 21'(amag);
   end

   always_ff @(posedge clock) begin
      if (mv[OUTS]) begin
         lin_ff     <= lin_in;
         ang_ff     <= ang_in;
         dist_ff    <= div_ff[DB].dist32;
         bear_ff    <= div_ff[DB].b16;
         reached_ff <= div_ff[DB].reached;
         wtg_ff     <= div_ff[DB].wtg;
         pre_ff     <= div_ff[DB].pre;
      end
   end

   assign rsp_tvalid = v_ff[OUTS];
   assign rsp_tdata  = {1'b0, wtg_ff, reached_ff, bear_ff, dist_ff, ang_ff, lin_ff};
   assign rsp_tuser  = pre_ff;

endmodule
